/* rtl/rcdr_pkg.sv */
// ----------------------------------------------------------------------------
// rcdr_pkg: shared types and constants of the colour distance replace unit
// Fixed point widths, the per-stage item records and the blend function.
// ----------------------------------------------------------------------------
package rcdr_pkg;

  localparam int unsigned RADIUS_FRAC_BITS = 4;
  localparam int unsigned RATIO_FRAC_BITS  = 16;

  localparam int unsigned CH_W     = 8;
  localparam int unsigned RGB_W    = 3 * CH_W;
  localparam int unsigned RADIUS_W = 13;
  localparam int unsigned SQ_W     = 2 * CH_W;                   // one squared diff
  localparam int unsigned D2_W     = SQ_W + 2;                   // sum of three
  localparam int unsigned N_W      = D2_W + 2 * RADIUS_FRAC_BITS;
  localparam int unsigned M_W      = 2 * RADIUS_W;               // radius squared
  localparam int unsigned DIV_STEPS  = 2 * RATIO_FRAC_BITS;
  localparam int unsigned Q_W        = DIV_STEPS + 1;
  localparam int unsigned SQRT_STEPS = RATIO_FRAC_BITS + 1;
  localparam int unsigned RES_W      = Q_W + 1;
  localparam int unsigned P_W        = RATIO_FRAC_BITS + 1;
  localparam int unsigned BL_W       = P_W + CH_W + 1;

  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = RGB_W;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KEY    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BYPASS = 8'd3;

  localparam logic [RADIUS_W-1:0] RADIUS_ONE = RADIUS_W'(1 << RADIUS_FRAC_BITS);
  localparam logic [P_W-1:0]      P_ONE      = P_W'(1 << RATIO_FRAC_BITS);

  typedef struct packed {
    logic [CH_W-1:0] alpha;
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic            hit;
  } pix_t;

  typedef struct packed {
    pix_t           pix;
    logic [Q_W-1:0] q;
    logic [M_W-1:0] r;
  } div_t;

  typedef struct packed {
    pix_t             pix;
    logic [Q_W-1:0]   x;
    logic [RES_W-1:0] res;
  } sqr_t;

  // floor((p*c + (1-p)*t) / 2^RATIO_FRAC_BITS)
  function automatic logic [CH_W-1:0] blend(logic [CH_W-1:0] c, logic [CH_W-1:0] t,
                                            logic [P_W-1:0] p);
    logic [BL_W-1:0] acc;
    acc = BL_W'(p) * BL_W'(c) + BL_W'(P_ONE - p) * BL_W'(t);
    return acc[RATIO_FRAC_BITS +: CH_W];
  endfunction

endpackage

/* rtl/rcdr_div_cell.sv */
// ----------------------------------------------------------------------------
// rcdr_div_cell: one quotient bit of the restoring ratio division
// Shifts the partial remainder, tries to subtract the divisor, records the bit.
// ----------------------------------------------------------------------------
module rcdr_div_cell import rcdr_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [M_W-1:0] m_i,
  input  logic           valid_i,
  input  div_t           data_i,
  output logic           ready_o,
  output logic           valid_o,
  output div_t           data_o,
  input  logic           ready_i
);

  logic   valid_q;
  div_t   data_q, data_d;
  logic [M_W:0] r2;
  logic         ge;

  assign ready_o = !valid_q || ready_i;

  // trial subtract; a zero divisor yields a zero quotient
  always_comb begin
    r2 = {data_i.r, 1'b0};
    ge = (m_i != '0) && (r2 >= {1'b0, m_i});
    data_d     = data_i;
    data_d.q   = {data_i.q[Q_W-2:0], ge};
    data_d.r   = ge ? M_W'(r2 - {1'b0, m_i}) : r2[M_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

/* rtl/rcdr_sqrt_cell.sv */
// ----------------------------------------------------------------------------
// rcdr_sqrt_cell: one root bit of the digit-by-digit square root
// Compares the remainder with root plus the cell's weight and updates both.
// ----------------------------------------------------------------------------
module rcdr_sqrt_cell import rcdr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [RES_W-1:0] weight_i,
  input  logic             valid_i,
  input  sqr_t             data_i,
  output logic             ready_o,
  output logic             valid_o,
  output sqr_t             data_o,
  input  logic             ready_i
);

  logic             valid_q;
  sqr_t             data_q, data_d;
  logic [RES_W-1:0] trial;
  logic             ge;

  assign ready_o = !valid_q || ready_i;

  // one root digit
  always_comb begin
    trial  = data_i.res + weight_i;
    ge     = ({1'b0, data_i.x} >= trial);
    data_d = data_i;
    if (ge) begin
      data_d.x   = Q_W'({1'b0, data_i.x} - trial);
      data_d.res = (data_i.res >> 1) + weight_i;
    end else begin
      data_d.res = data_i.res >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

/* rtl/rgb_color_distance_replace_unit.sv */
// ----------------------------------------------------------------------------
// rgb_color_distance_replace_unit: colour key replace with soft falloff
// Squares, distance test, 32 division cells, 17 root cells, then the blend into
// the output register. Throughput one item per cycle; each stage holds its
// item while the next one stalls. Reset clears all valid flags and the
// registers (radius to 1.0, bypass off, colours to 0).
// ----------------------------------------------------------------------------
module rgb_color_distance_replace_unit import rcdr_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [CH_W-1:0]       in_alpha_i,
  input  logic [CH_W-1:0]       in_red_i,
  input  logic [CH_W-1:0]       in_green_i,
  input  logic [CH_W-1:0]       in_blue_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [CH_W-1:0]       out_alpha_o,
  output logic [CH_W-1:0]       out_red_o,
  output logic [CH_W-1:0]       out_green_o,
  output logic [CH_W-1:0]       out_blue_o
);

  // configuration registers
  logic [RGB_W-1:0]    key_q, target_q;
  logic [RADIUS_W-1:0] radius_q;
  logic                bypass_q;
  logic [M_W-1:0]      m_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q    <= '0;
      target_q <= '0;
      radius_q <= RADIUS_ONE;
      bypass_q <= 1'b0;
      m_q      <= M_W'(RADIUS_ONE * RADIUS_ONE);
    end else begin
      m_q <= M_W'(radius_q) * M_W'(radius_q);
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          REG_KEY:    key_q    <= cfg_data_i[RGB_W-1:0];
          REG_TARGET: target_q <= cfg_data_i[RGB_W-1:0];
          REG_RADIUS: radius_q <= cfg_data_i[RADIUS_W-1:0];
          REG_BYPASS: bypass_q <= cfg_data_i[0];
          default:    ;
        endcase
      end
    end
  end

  // stage A: squared channel distances
  logic            a_valid_q, a_ready;
  pix_t            a_pix_q;
  logic [SQ_W-1:0] a_sr_q, a_sg_q, a_sb_q;
  logic signed [CH_W:0] dr, dg, db;
  logic signed [SQ_W+1:0] dr_x, dg_x, db_x;
  logic            b_ready;

  assign a_ready    = !a_valid_q || b_ready;
  assign in_stall_o = !a_ready;

  always_comb begin
    dr = $signed({1'b0, in_red_i})   - $signed({1'b0, key_q[2*CH_W +: CH_W]});
    dg = $signed({1'b0, in_green_i}) - $signed({1'b0, key_q[CH_W +: CH_W]});
    db = $signed({1'b0, in_blue_i})  - $signed({1'b0, key_q[0 +: CH_W]});
    // widen before squaring
    dr_x = (SQ_W+2)'(dr);
    dg_x = (SQ_W+2)'(dg);
    db_x = (SQ_W+2)'(db);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (a_ready) begin
      a_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_ready) begin
      a_pix_q <= '{alpha: in_alpha_i, red: in_red_i, green: in_green_i,
                   blue: in_blue_i, hit: 1'b0};
      a_sr_q  <= SQ_W'(dr_x * dr_x);
      a_sg_q  <= SQ_W'(dg_x * dg_x);
      a_sb_q  <= SQ_W'(db_x * db_x);
    end
  end

  // stage B: distance test and division set-up
  logic           b_valid_q;
  div_t           b_data_q, b_data_d;
  logic [D2_W-1:0] d2;
  logic [N_W-1:0]  n;
  logic            match, q0;
  logic            div_rdy [0:DIV_STEPS];
  logic            div_vld [0:DIV_STEPS];
  div_t            div_dat [0:DIV_STEPS];

  assign b_ready = !b_valid_q || div_rdy[0];

  always_comb begin
    d2    = D2_W'(a_sr_q) + D2_W'(a_sg_q) + D2_W'(a_sb_q);
    n     = {d2, (2 * RADIUS_FRAC_BITS)'(0)};
    match = (n <= N_W'(m_q));
    // zero radius leaves the ratio at zero
    q0    = (m_q != '0) && (n == N_W'(m_q));
    b_data_d     = '0;
    b_data_d.pix = a_pix_q;
    b_data_d.pix.hit = match && !bypass_q;
    b_data_d.q   = Q_W'(q0);
    b_data_d.r   = (q0 || !match) ? '0 : n[M_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (b_ready) begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_ready) begin
      b_data_q <= b_data_d;
    end
  end

  // division chain
  assign div_vld[0] = b_valid_q;
  assign div_dat[0] = b_data_q;

  logic sq_rdy [0:SQRT_STEPS];
  logic sq_vld [0:SQRT_STEPS];
  sqr_t sq_dat [0:SQRT_STEPS];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    rcdr_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .m_i     (m_q),
      .valid_i (div_vld[k]),
      .data_i  (div_dat[k]),
      .ready_o (div_rdy[k]),
      .valid_o (div_vld[k+1]),
      .data_o  (div_dat[k+1]),
      .ready_i (div_rdy[k+1])
    );
  end

  // square root chain
  assign div_rdy[DIV_STEPS] = sq_rdy[0];
  assign sq_vld[0]          = div_vld[DIV_STEPS];
  assign sq_dat[0]          = '{pix: div_dat[DIV_STEPS].pix, x: div_dat[DIV_STEPS].q,
                                res: '0};

  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
    rcdr_sqrt_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .weight_i (RES_W'(1) << (DIV_STEPS - 2 * j)),
      .valid_i  (sq_vld[j]),
      .data_i   (sq_dat[j]),
      .ready_o  (sq_rdy[j]),
      .valid_o  (sq_vld[j+1]),
      .data_o   (sq_dat[j+1]),
      .ready_i  (sq_rdy[j+1])
    );
  end

  // blend into the output register
  logic            o_valid_q, o_ready;
  pix_t            o_pix_q, o_pix_d;
  logic [P_W-1:0]  p;
  pix_t            last;

  assign o_ready = !o_valid_q || !out_stall_i;
  assign sq_rdy[SQRT_STEPS] = o_ready;

  always_comb begin
    last    = sq_dat[SQRT_STEPS].pix;
    p       = sq_dat[SQRT_STEPS].res[P_W-1:0];
    o_pix_d = last;
    if (last.hit) begin
      o_pix_d.red   = blend(last.red,   target_q[2*CH_W +: CH_W], p);
      o_pix_d.green = blend(last.green, target_q[CH_W +: CH_W],   p);
      o_pix_d.blue  = blend(last.blue,  target_q[0 +: CH_W],      p);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q <= 1'b0;
    end else if (o_ready) begin
      o_valid_q <= sq_vld[SQRT_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (o_ready) begin
      o_pix_q <= o_pix_d;
    end
  end

  assign out_valid_o = o_valid_q;
  assign out_alpha_o = o_pix_q.alpha;
  assign out_red_o   = o_pix_q.red;
  assign out_green_o = o_pix_q.green;
  assign out_blue_o  = o_pix_q.blue;

endmodule

/* tb/rgb_color_distance_replace_unit_test.sv */
// ----------------------------------------------------------------------------
// rgb_color_distance_replace_unit_test: self-checking bench of the replace unit
// Drives ARGB pixels in bursts, stalls the output on its own pattern and
// compares each output pixel with an exact integer model of the key blend.
// ----------------------------------------------------------------------------
module rgb_color_distance_replace_unit_test;
  import rcdr_pkg::*;

  typedef struct packed {
    logic [7:0] a;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } argb_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [7:0]            in_alpha_i, in_red_i, in_green_i, in_blue_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic [7:0]            out_alpha_o, out_red_o, out_green_o, out_blue_o;

  // model copy of the registers
  logic [23:0] key_q, target_q;
  logic [12:0] radius_q;
  logic        bypass_q;

  argb_t pixel_queue[$];
  argb_t expected_pixels[$];
  int    n_errors;
  int    n_checked;
  int    hold_cycles;
  bit    send_enable;
  int    burst_left, gap_left;

  rgb_color_distance_replace_unit u_dut (.*);

  // clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // exact blend model
  function automatic argb_t replace_pixel(argb_t px);
    argb_t       res;
    int          dr, dg, db;
    longint unsigned d2, n, m, rem, q, x, root, bit_v, one;
    one = 64'd1 << RATIO_FRAC_BITS;
    res = px;
    if (bypass_q) return res;
    dr = int'(px.r) - int'(key_q[23:16]);
    dg = int'(px.g) - int'(key_q[15:8]);
    db = int'(px.b) - int'(key_q[7:0]);
    d2 = longint'(dr*dr + dg*dg + db*db);
    n  = d2 << (2*RADIUS_FRAC_BITS);
    m  = longint'(radius_q) * longint'(radius_q);
    if (n > m) return res;
    root = 0;
    if (m != 0) begin
      q = n / m;
      rem = n % m;
      for (int i = 0; i < 2*RATIO_FRAC_BITS; i++) begin
        q = q << 1;
        rem = rem << 1;
        if (rem >= m) begin
          rem -= m;
          q |= 1;
        end
      end
      x = q;
      bit_v = 64'd1 << 62;
      while (bit_v > x) bit_v >>= 2;
      while (bit_v != 0) begin
        if (x >= root + bit_v) begin
          x -= root + bit_v;
          root = (root >> 1) + bit_v;
        end else begin
          root >>= 1;
        end
        bit_v >>= 2;
      end
    end
    res.r = 8'((root*px.r + (one-root)*target_q[23:16]) >> RATIO_FRAC_BITS);
    res.g = 8'((root*px.g + (one-root)*target_q[15:8]) >> RATIO_FRAC_BITS);
    res.b = 8'((root*px.b + (one-root)*target_q[7:0]) >> RATIO_FRAC_BITS);
    return res;
  endfunction

  // pixel driver: bursts and gaps; the head of the queue is the next item to offer
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      burst_left <= 0;
      gap_left   <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        expected_pixels.push_back(replace_pixel(pixel_queue.pop_front()));
      end
      if (in_valid_i && in_stall_o) begin
        // hold payload
      end else if (gap_left > 0) begin
        gap_left   <= gap_left - 1;
        in_valid_i <= 1'b0;
      end else if (send_enable && pixel_queue.size() > 0) begin
        {in_alpha_i, in_red_i, in_green_i, in_blue_i} <= pixel_queue[0];
        in_valid_i <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left   <= ($urandom_range(0, 2) == 0) ? $urandom_range(1, 8) : 0;
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // output stall pattern, with an optional long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_cycles > 0) begin
      out_stall_i <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall_i <= ($urandom_range(0, 3) == 0);
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    argb_t exp_px;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_pixels.size() == 0) begin
        $error("unexpected output pixel %h", {out_alpha_o, out_red_o, out_green_o,
                                              out_blue_o});
        n_errors++;
      end else begin
        exp_px = expected_pixels.pop_front();
        n_checked++;
        if (out_alpha_o !== exp_px.a) begin
          $error("out_alpha expected %0d got %0d", exp_px.a, out_alpha_o);
          n_errors++;
        end
        if (out_red_o !== exp_px.r) begin
          $error("out_red expected %0d got %0d", exp_px.r, out_red_o);
          n_errors++;
        end
        if (out_green_o !== exp_px.g) begin
          $error("out_green expected %0d got %0d", exp_px.g, out_green_o);
          n_errors++;
        end
        if (out_blue_o !== exp_px.b) begin
          $error("out_blue expected %0d got %0d", exp_px.b, out_blue_o);
          n_errors++;
        end
      end
    end
  end

  // register write, only while the pipeline is empty
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [23:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_KEY:    key_q    = data;
      REG_TARGET: target_q = data;
      REG_RADIUS: radius_q = data[12:0];
      REG_BYPASS: bypass_q = data[0];
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (pixel_queue.size() > 0 || in_valid_i || expected_pixels.size() > 0)
      @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic add_pixel(input argb_t px);
    pixel_queue.push_back(px);
  endtask

  // a pixel near the key, each channel within spread of the key channel (mod 256)
  task automatic add_near_key(input int spread);
    argb_t px;
    px.a = 8'($urandom);
    px.r = 8'(int'(key_q[23:16]) + $urandom_range(0, 2*spread) - spread);
    px.g = 8'(int'(key_q[15:8])  + $urandom_range(0, 2*spread) - spread);
    px.b = 8'(int'(key_q[7:0])   + $urandom_range(0, 2*spread) - spread);
    add_pixel(px);
  endtask

  task automatic random_phase(input int count, input int spread);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 3) == 0) add_pixel(argb_t'($urandom));
      else add_near_key(spread);
    end
  endtask

  // stimulus sequence
  initial begin
    logic [12:0] rad;
    int spread;
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    in_valid_i = 1'b0;
    {in_alpha_i, in_red_i, in_green_i, in_blue_i} = '0;
    out_stall_i = 1'b0;
    key_q = '0; target_q = '0; radius_q = RADIUS_ONE; bypass_q = 1'b0;
    n_errors = 0; n_checked = 0; hold_cycles = 0; send_enable = 1'b1;
    repeat (5) @(posedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(posedge clk_i);

    // directed: reset settings, extremes
    add_pixel('0);
    add_pixel('1);
    add_pixel(32'h80000001);
    add_pixel(32'h7F010000);
    wait_drained();
    write_reg(REG_KEY, 24'h102030);
    write_reg(REG_TARGET, 24'hFF00FF);
    write_reg(REG_RADIUS, 24'd8191);
    add_pixel(32'hFF102030);        // exact key
    add_pixel(32'h00FFFFFF);
    add_pixel(32'h55000000);
    add_pixel(32'hAA112131);
    wait_drained();
    // zero radius: only the key itself matches
    write_reg(REG_RADIUS, 24'd0);
    add_pixel(32'h12102030);
    add_pixel(32'h12102031);
    wait_drained();
    // unused bits and two unknown indexes
    write_reg(REG_RADIUS, 24'hFFE010);
    write_reg(8'd7, 24'hFFFFFF);
    write_reg(8'hFF, 24'h123456);
    add_pixel(32'h01102030);
    add_pixel(32'h01112030);
    wait_drained();
    write_reg(REG_BYPASS, 24'hFFFFFF);
    add_pixel(32'h99102030);
    add_pixel(32'h0F0F0F0F);
    wait_drained();
    write_reg(REG_BYPASS, 24'h0);

    // random phases over several settings; the first one has a long hold-off
    for (int ph = 0; ph < 9; ph++) begin
      write_reg(REG_KEY, 24'($urandom));
      write_reg(REG_TARGET, 24'($urandom));
      case (ph)
        0: rad = 13'd8191;
        1: rad = 13'd1;
        2: rad = 13'd0;
        default: rad = 13'($urandom_range(1, 2000));
      endcase
      write_reg(REG_RADIUS, 24'(rad));
      write_reg(REG_BYPASS, 24'(ph == 5));
      spread = (rad >> RADIUS_FRAC_BITS) / 2 + 1;
      if (ph == 0) hold_cycles = 300;
      random_phase(100, spread);
      wait_drained();
    end

    $display("checked %0d output pixels over nine random register settings", n_checked);
    $display("plus directed extremes, zero radius, bypass and unused register bits");
    if (n_errors == 0) begin
      $display("rgb_color_distance_replace_unit_test: PASS");
    end else begin
      $display("rgb_color_distance_replace_unit_test: FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("rgb_color_distance_replace_unit_test: FAIL");
    $finish;
  end

endmodule
